>>> sv/smpe_pkg.sv
package smpe_pkg;

    typedef enum logic [1:0] {
        FUNC_REPORT = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_POWER  = 2'd2,
        FUNC_SPARE  = 2'd3
    } func_t;

    localparam logic CFG_WHEEL_ENABLED = 1'b0;
    localparam logic CFG_SEND_PERIOD   = 1'b1;

    localparam logic [6:0] SEND_PERIOD_RESET = 7'd50;

    localparam logic [6:0] ID_LEAD     = 7'h4D;
    localparam logic [6:0] ID_WHEEL    = 7'h5A;
    localparam logic [6:0] ID_PLAIN    = 7'h33;
    localparam logic [6:0] ID_TRAIL    = 7'h40;
    localparam logic [6:0] ID_PAD      = 7'h00;

    localparam logic [2:0] ID_LAST_WHEEL  = 3'd5;
    localparam logic [2:0] ID_LAST_PLAIN  = 3'd4;
    localparam logic [2:0] PKT_LAST_WHEEL = 3'd3;
    localparam logic [2:0] PKT_LAST_PLAIN = 3'd2;

    typedef struct packed {
        logic            is_id;
        logic            wheel;
        logic            has_pkt;
        logic [3:0][6:0] pkt;
    } job_t;

    function automatic logic [15:0] sat17(input logic [16:0] v);
        logic [15:0] r;
        if (v[16] != v[15])
        begin
            r = v[16] ? 16'h8000 : 16'h7FFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> sv/smpe_front.sv
module smpe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [7:0]           button_bits,
    input  logic signed [7:0]    delta_x,
    input  logic signed [7:0]    delta_y,
    input  logic signed [7:0]    delta_wheel,
    input  logic                 powered,
    input  logic                 wheel_enabled,
    input  logic [6:0]           send_period,
    input  logic                 q_full,
    output logic                 push,
    output smpe_pkg::job_t       job
);
    import smpe_pkg::*;

    logic [15:0] acc_x_reg, acc_x_next;
    logic [15:0] acc_y_reg, acc_y_next;
    logic [15:0] acc_z_reg, acc_z_next;
    logic [2:0]  cur_buttons_reg, cur_buttons_next;
    logic [2:0]  sent_buttons_reg, sent_buttons_next;
    logic [6:0]  tick_count_reg, tick_count_next;
    logic        send_pending_reg, send_pending_next;
    logic        start_pending_reg, start_pending_next;
    logic        mouse_on_reg, mouse_on_next;

    logic        accept;
    logic [16:0] sum_x, sum_y, sum_z;
    logic [7:0]  tick_inc;
    logic        serve, start, has_pkt;
    logic [15:0] ax, ay, az;
    logic [2:0]  btn;
    logic [7:0]  cx, cy;
    logic [3:0]  cz;
    logic        x_hi, x_lo, y_hi, y_lo, z_hi, z_lo;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign sum_x    = {acc_x_reg[15], acc_x_reg} + {{9{delta_x[7]}}, delta_x};
    assign sum_y    = {acc_y_reg[15], acc_y_reg} - {{9{delta_y[7]}}, delta_y};
    assign sum_z    = {acc_z_reg[15], acc_z_reg} + {{9{delta_wheel[7]}}, delta_wheel};
    assign tick_inc = {1'b0, tick_count_reg} + 8'd1;

    always_comb
    begin
        acc_x_next         = acc_x_reg;
        acc_y_next         = acc_y_reg;
        acc_z_next         = acc_z_reg;
        cur_buttons_next   = cur_buttons_reg;
        sent_buttons_next  = sent_buttons_reg;
        tick_count_next    = tick_count_reg;
        send_pending_next  = send_pending_reg;
        start_pending_next = start_pending_reg;
        mouse_on_next      = mouse_on_reg;
        serve   = 1'b0;
        start   = 1'b0;
        has_pkt = 1'b0;
        ax = 16'd0;
        ay = 16'd0;
        az = 16'd0;
        btn = 3'd0;
        cx = 8'd0;
        cy = 8'd0;
        cz = 4'd0;
        x_hi = 1'b0;
        x_lo = 1'b0;
        y_hi = 1'b0;
        y_lo = 1'b0;
        z_hi = 1'b0;
        z_lo = 1'b0;

        if (accept)
        begin
            unique case (func_t'(func))
                FUNC_REPORT:
                begin
                    if (mouse_on_reg)
                    begin
                        cur_buttons_next = wheel_enabled ? button_bits[2:0]
                                                         : {1'b0, button_bits[1:0]};
                        acc_x_next = sat17(sum_x);
                        acc_y_next = sat17(sum_y);
                        acc_z_next = sat17(sum_z);
                    end
                end
                FUNC_TICK:
                begin
                    if (tick_inc >= {1'b0, send_period})
                    begin
                        tick_count_next   = 7'd0;
                        send_pending_next = 1'b1;
                    end
                    else
                    begin
                        tick_count_next = tick_inc[6:0];
                    end
                end
                FUNC_POWER:
                begin
                    if (powered)
                    begin
                        if (!mouse_on_reg)
                        begin
                            mouse_on_next      = 1'b1;
                            start_pending_next = 1'b1;
                            send_pending_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        mouse_on_next = 1'b0;
                    end
                end
                FUNC_SPARE:
                begin
                end
                default:
                begin
                end
            endcase

            serve = send_pending_next && mouse_on_next;
            if (serve)
            begin
                start             = start_pending_next;
                send_pending_next = 1'b0;
                if (start)
                begin
                    start_pending_next = 1'b0;
                end
                ax  = start ? 16'd0 : acc_x_next;
                ay  = start ? 16'd0 : acc_y_next;
                az  = start ? 16'd0 : acc_z_next;
                btn = start ? 3'd0 : cur_buttons_next;
                acc_x_next       = ax;
                acc_y_next       = ay;
                acc_z_next       = az;
                cur_buttons_next = btn;

                x_hi = !ax[15] && (ax[14:7] != 8'h00);
                x_lo =  ax[15] && (ax[14:7] != 8'hFF);
                y_hi = !ay[15] && (ay[14:7] != 8'h00);
                y_lo =  ay[15] && (ay[14:7] != 8'hFF);
                z_hi = !az[15] && (az[14:3] != 12'h000);
                z_lo =  az[15] && (az[14:3] != 12'hFFF);
                cx = x_hi ? 8'h7F : (x_lo ? 8'h80 : ax[7:0]);
                cy = y_hi ? 8'h7F : (y_lo ? 8'h80 : ay[7:0]);
                cz = z_hi ? 4'h7 : (z_lo ? 4'h8 : az[3:0]);

                has_pkt = (btn != sent_buttons_reg) || (ax != 16'd0)
                          || (ay != 16'd0) || (az != 16'd0);
                if (has_pkt)
                begin
                    acc_x_next        = ax - {{8{cx[7]}}, cx};
                    acc_y_next        = ay - {{8{cy[7]}}, cy};
                    acc_z_next        = az - {{12{cz[3]}}, cz};
                    sent_buttons_next = btn;
                end
            end
        end
    end

    always_comb
    begin
        job.is_id   = start;
        job.wheel   = wheel_enabled;
        job.has_pkt = has_pkt;
        job.pkt[0]  = {1'b1, btn[0], btn[1], cy[7:6], cx[7:6]};
        job.pkt[1]  = {1'b0, cx[5:0]};
        job.pkt[2]  = {1'b0, cy[5:0]};
        job.pkt[3]  = {2'b00, btn[2], cz};
    end

    assign push = serve && (start || has_pkt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg         <= 16'd0;
            acc_y_reg         <= 16'd0;
            acc_z_reg         <= 16'd0;
            cur_buttons_reg   <= 3'd0;
            sent_buttons_reg  <= 3'd0;
            tick_count_reg    <= 7'd0;
            send_pending_reg  <= 1'b0;
            start_pending_reg <= 1'b1;
            mouse_on_reg      <= 1'b0;
        end
        else
        begin
            acc_x_reg         <= acc_x_next;
            acc_y_reg         <= acc_y_next;
            acc_z_reg         <= acc_z_next;
            cur_buttons_reg   <= cur_buttons_next;
            sent_buttons_reg  <= sent_buttons_next;
            tick_count_reg    <= tick_count_next;
            send_pending_reg  <= send_pending_next;
            start_pending_reg <= start_pending_next;
            mouse_on_reg      <= mouse_on_next;
        end
    end

endmodule

>>> sv/smpe_queue.sv
module smpe_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  smpe_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output smpe_pkg::job_t head_job
);
    import smpe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_job = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/smpe_back.sv
module smpe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  smpe_pkg::job_t head_job,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [6:0]     serial_byte,
    output logic           is_id,
    output logic           last_byte
);
    import smpe_pkg::*;

    job_t       job_reg;
    logic       busy_reg, busy_next;
    logic       id_phase_reg, id_phase_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] byte_reg;
    logic       is_id_reg;
    logic       last_reg;

    logic       emit, job_ld, seg_end, is_last;
    logic [6:0] cur_byte;
    logic [2:0] id_last, pkt_last;

    assign id_last  = job_reg.wheel ? ID_LAST_WHEEL : ID_LAST_PLAIN;
    assign pkt_last = job_reg.wheel ? PKT_LAST_WHEEL : PKT_LAST_PLAIN;

    always_comb
    begin
        if (id_phase_reg)
        begin
            unique case (idx_reg)
                3'd0:    cur_byte = ID_LEAD;
                3'd1:    cur_byte = job_reg.wheel ? ID_WHEEL : ID_PLAIN;
                3'd2:    cur_byte = ID_TRAIL;
                default: cur_byte = ID_PAD;
            endcase
            seg_end = (idx_reg == id_last);
            is_last = seg_end && !job_reg.has_pkt;
        end
        else
        begin
            cur_byte = job_reg.pkt[idx_reg[1:0]];
            seg_end  = (idx_reg == pkt_last);
            is_last  = seg_end;
        end
    end

    assign emit   = busy_reg && (!out_valid_reg || out_ready);
    assign job_ld = q_valid && (!busy_reg || (emit && is_last));
    assign pop    = job_ld;

    always_comb
    begin
        busy_next     = busy_reg;
        id_phase_next = id_phase_reg;
        idx_next      = idx_reg;
        if (job_ld)
        begin
            busy_next     = 1'b1;
            id_phase_next = head_job.is_id;
            idx_next      = 3'd0;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else if (id_phase_reg && seg_end)
            begin
                id_phase_next = 1'b0;
                idx_next      = 3'd0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_ld)
        begin
            job_reg <= head_job;
        end
        if (emit)
        begin
            byte_reg  <= cur_byte;
            is_id_reg <= id_phase_reg;
            last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            id_phase_reg  <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            id_phase_reg  <= id_phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign serial_byte = byte_reg;
    assign is_id       = is_id_reg;
    assign last_byte   = last_reg;

`ifndef ASSERT_OFF
    a_id_index: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && id_phase_reg |-> idx_reg <= id_last)
        else $error("id index past end of string");

    a_pkt_index: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !id_phase_reg |-> job_reg.has_pkt && idx_reg <= pkt_last)
        else $error("packet index past end or no packet in job");

    a_load_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && emit && is_last && !q_valid |=> !busy_reg && out_valid_reg && last_reg)
        else $error("sequencer did not finish after last word");
`endif

endmodule

>>> sv/serial_mouse_packet_encoder.sv
// Serial mouse packet encoder.
// Input channel (in_valid/in_ready) takes one word per cycle while the job
// queue has room: a report, a millisecond tick or a power line change, chosen
// by func. Each accepted word updates the movement accumulators and send
// timer in the same cycle; when a send is due it queues a job holding the id
// string flag and the packet bytes for that word.
// Output channel (out_valid/out_ready) gives seven-bit bytes one per cycle
// while out_ready is high, last_byte marking the final byte of the word that
// caused them; words that cause nothing give no bytes.
// The first byte passes the job queue, job register and output byte register.
// Throughput: one input word per cycle while the job queue has room; the
// byte sequencer gives one byte per cycle while the receiver keeps taking
// them, up to ten bytes per word, and so sets the sustained rate when sends follow one another.
// The user must write configuration (cfg_write/cfg_index/cfg_data) only
// while idle; the block does not enforce it. Reset clears the accumulators,
// timer and queue, marks the id string as due and sets send_period to 50 and
// wheel_enabled to 0. A stalled receiver holds the output byte; the queue
// then fills and in_ready drops until bytes drain.
module serial_mouse_packet_encoder #(
    parameter int JOB_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [6:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [7:0]        button_bits,
    input  logic signed [7:0] delta_x,
    input  logic signed [7:0] delta_y,
    input  logic signed [7:0] delta_wheel,
    input  logic              powered,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [6:0]        serial_byte,
    output logic              is_id,
    output logic              last_byte
);
    import smpe_pkg::*;

    logic       wheel_enabled_reg;
    logic [6:0] send_period_reg;
    logic       q_full, q_push, q_pop, q_valid;
    job_t       push_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_enabled_reg <= 1'b0;
            send_period_reg   <= SEND_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WHEEL_ENABLED: wheel_enabled_reg <= cfg_data[0];
                CFG_SEND_PERIOD:   send_period_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    smpe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .button_bits   (button_bits),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .delta_wheel   (delta_wheel),
        .powered       (powered),
        .wheel_enabled (wheel_enabled_reg),
        .send_period   (send_period_reg),
        .q_full        (q_full),
        .push          (q_push),
        .job           (push_job)
    );

    smpe_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .head_job (head_job)
    );

    smpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .head_job    (head_job),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_byte (serial_byte),
        .is_id       (is_id),
        .last_byte   (last_byte)
    );

endmodule

>>> dv/serial_mouse_packet_encoder_test.sv
`timescale 1ns / 100ps

module serial_mouse_packet_encoder_test;

    import smpe_pkg::*;

    typedef struct {
        func_t             func;
        logic [7:0]        buttons;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] dz;
        logic              pwr;
    } mouse_word_t;

    typedef struct {
        logic [6:0] data;
        logic       id;
        logic       last;
    } serial_out_t;

    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_write   = 1'b0;
    logic              cfg_index   = CFG_WHEEL_ENABLED;
    logic [6:0]        cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [1:0]        func        = FUNC_REPORT;
    logic [7:0]        button_bits = '0;
    logic signed [7:0] delta_x     = '0;
    logic signed [7:0] delta_y     = '0;
    logic signed [7:0] delta_wheel = '0;
    logic              powered     = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [6:0]        serial_byte;
    logic              is_id;
    logic              last_byte;

    serial_out_t serial_bytes_due[$];
    int          bad_bytes     = 0;
    int          quiet_cycles  = 0;
    int          hold_request  = 0;
    int          burst_left    = 0;
    bit          steady_sender = 1'b0;

    logic signed [15:0] move_x       = '0;
    logic signed [15:0] move_y       = '0;
    logic signed [15:0] move_z       = '0;
    logic [2:0]         buttons_now  = '0;
    logic [2:0]         buttons_sent = '0;
    logic [6:0]         tick_cnt     = '0;
    logic               send_due     = 1'b0;
    logic               id_due       = 1'b1;
    logic               power_on     = 1'b0;
    logic               wheel_mode   = 1'b0;
    logic [6:0]         period       = SEND_PERIOD_RESET;

    serial_mouse_packet_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .button_bits (button_bits),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .delta_wheel (delta_wheel),
        .powered     (powered),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_byte (serial_byte),
        .is_id       (is_id),
        .last_byte   (last_byte)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] saturate16(input int v);
        int r;
        r = v;
        if (r < -32768)
        begin
            r = -32768;
        end
        if (r > 32767)
        begin
            r = 32767;
        end
        return 16'(r);
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void push_byte(input logic [6:0] data, input logic id);
        serial_bytes_due.push_back('{data: data, id: id, last: 1'b0});
    endfunction

    task automatic encode_word(input mouse_word_t w);
        int         first;
        int         t;
        int         cx;
        int         cy;
        int         cz;
        logic [7:0] bx;
        logic [7:0] by;
        logic [3:0] bz;
        first = serial_bytes_due.size();
        case (w.func)
            FUNC_REPORT:
            begin
                if (power_on)
                begin
                    buttons_now = w.buttons[2:0] & (wheel_mode ? 3'b111 : 3'b011);
                    move_x = saturate16(int'(move_x) + int'(w.dx));
                    move_y = saturate16(int'(move_y) - int'(w.dy));
                    move_z = saturate16(int'(move_z) + int'(w.dz));
                end
            end
            FUNC_TICK:
            begin
                t = int'(tick_cnt) + 1;
                if (t >= int'(period))
                begin
                    tick_cnt = '0;
                    send_due = 1'b1;
                end
                else
                begin
                    tick_cnt = 7'(t);
                end
            end
            FUNC_POWER:
            begin
                if (w.pwr)
                begin
                    if (!power_on)
                    begin
                        power_on = 1'b1;
                        id_due   = 1'b1;
                        send_due = 1'b1;
                    end
                end
                else
                begin
                    power_on = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (send_due && power_on)
        begin
            send_due = 1'b0;
            if (id_due)
            begin
                id_due      = 1'b0;
                move_x      = '0;
                move_y      = '0;
                move_z      = '0;
                buttons_now = '0;
                push_byte(ID_LEAD, 1'b1);
                push_byte(wheel_mode ? ID_WHEEL : ID_PLAIN, 1'b1);
                push_byte(ID_TRAIL, 1'b1);
                repeat (wheel_mode ? 3 : 2) push_byte(ID_PAD, 1'b1);
            end
            if (buttons_now != buttons_sent || move_x != 0 || move_y != 0 || move_z != 0)
            begin
                cx = clamp(int'(move_x), -128, 127);
                cy = clamp(int'(move_y), -128, 127);
                cz = clamp(int'(move_z), -8, 7);
                move_x = saturate16(int'(move_x) - cx);
                move_y = saturate16(int'(move_y) - cy);
                move_z = saturate16(int'(move_z) - cz);
                buttons_sent = buttons_now;
                bx = 8'(cx);
                by = 8'(cy);
                bz = 4'(cz);
                push_byte({1'b1, buttons_now[0], buttons_now[1], by[7:6], bx[7:6]}, 1'b0);
                push_byte({1'b0, bx[5:0]}, 1'b0);
                push_byte({1'b0, by[5:0]}, 1'b0);
                if (wheel_mode)
                begin
                    push_byte({2'b00, buttons_now[2], bz}, 1'b0);
                end
            end
        end
        if (serial_bytes_due.size() > first)
        begin
            serial_bytes_due[serial_bytes_due.size() - 1].last = 1'b1;
        end
    endtask

    function automatic mouse_word_t word_of(input func_t f, input logic [7:0] b,
                                            input int x, input int y, input int z,
                                            input logic p);
        mouse_word_t w;
        w.func    = f;
        w.buttons = b;
        w.dx      = 8'(x);
        w.dy      = 8'(y);
        w.dz      = 8'(z);
        w.pwr     = p;
        return w;
    endfunction

    function automatic mouse_word_t random_word(input int report_pct, input int tick_pct);
        mouse_word_t w;
        int          r;
        r = $urandom_range(0, 99);
        if (r < report_pct)
        begin
            w.func = FUNC_REPORT;
        end
        else if (r < report_pct + tick_pct)
        begin
            w.func = FUNC_TICK;
        end
        else if (r < 97)
        begin
            w.func = FUNC_POWER;
        end
        else
        begin
            w.func = FUNC_SPARE;
        end
        w.buttons = 8'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            w.dx = 8'($urandom_range(0, 6) - 3);
            w.dy = 8'($urandom_range(0, 6) - 3);
            w.dz = 8'($urandom_range(0, 6) - 3);
        end
        else
        begin
            w.dx = 8'($urandom);
            w.dy = 8'($urandom);
            w.dz = 8'($urandom);
        end
        w.pwr = (w.func == FUNC_POWER) ? ($urandom_range(0, 3) != 0) : 1'($urandom);
        return w;
    endfunction

    task automatic send_word(input mouse_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        func        <= w.func;
        button_bits <= w.buttons;
        delta_x     <= w.dx;
        delta_y     <= w.dy;
        delta_wheel <= w.dz;
        powered     <= w.pwr;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        encode_word(w);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (serial_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_WHEEL_ENABLED)
        begin
            wheel_mode = value[0];
        end
        else
        begin
            period = value;
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_power_and_id();
        write_reg(CFG_SEND_PERIOD, 7'd1);
        write_reg(CFG_WHEEL_ENABLED, 7'd0);
        send_word(word_of(FUNC_REPORT, 8'hFF, 127, -128, 127, 1'b1));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b0));
        send_word(word_of(FUNC_SPARE, 8'hFF, -1, -1, -1, 1'b1));
        send_word(word_of(FUNC_POWER, 8'h00, 0, 0, 0, 1'b0));
        send_word(word_of(FUNC_POWER, 8'h00, 0, 0, 0, 1'b1));
        send_word(word_of(FUNC_POWER, 8'hFF, -1, -1, -1, 1'b1));
        settle();
    endtask

    task automatic test_packet_layout();
        send_word(word_of(FUNC_REPORT, 8'hFF, 127, -128, 127, 1'b0));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b1));
        send_word(word_of(FUNC_TICK, 8'hFF, -1, -1, -1, 1'b0));
        send_word(word_of(FUNC_REPORT, 8'h00, -128, 127, -128, 1'b1));
        send_word(word_of(FUNC_SPARE, 8'h00, 0, 0, 0, 1'b0));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b1));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b1));
        settle();
        write_reg(CFG_WHEEL_ENABLED, 7'h7F);
        send_word(word_of(FUNC_POWER, 8'h00, 0, 0, 0, 1'b0));
        send_word(word_of(FUNC_REPORT, 8'h07, 5, 5, 5, 1'b1));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b0));
        send_word(word_of(FUNC_POWER, 8'h00, 0, 0, 0, 1'b1));
        send_word(word_of(FUNC_REPORT, 8'hFC, 1, 1, -128, 1'b0));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b0));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b0));
        send_word(word_of(FUNC_REPORT, 8'h03, 0, 0, 127, 1'b1));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b1));
        settle();
    endtask

    task automatic test_saturation();
        // drive X and the wheel past full scale upwards, Y past full scale downwards
        send_word(word_of(FUNC_POWER, 8'h00, 0, 0, 0, 1'b1));
        repeat (262)
        begin
            send_word(word_of(FUNC_REPORT, 8'($urandom), $urandom_range(126, 127),
                              $urandom_range(126, 127), $urandom_range(126, 127),
                              1'($urandom)));
        end
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b1));
        send_word(word_of(FUNC_TICK, 8'h00, 0, 0, 0, 1'b1));
        settle();
    endtask

    task automatic test_back_pressure();
        // hold the output side so the job queue fills and the input stalls
        steady_sender = 1'b1;
        hold_request  = HOLD_OFF_CYCLES;
        repeat (12)
        begin
            send_word(random_word(100, 0));
            send_word(word_of(FUNC_TICK, 8'($urandom), 0, 0, 0, 1'b1));
        end
        steady_sender = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic();
        logic [6:0] periods [5];
        periods[0] = 7'd3;
        periods[1] = 7'd0;
        periods[2] = 7'd127;
        periods[3] = 7'd100;
        periods[4] = 7'($urandom_range(1, 20));
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(CFG_WHEEL_ENABLED, 7'($urandom));
            write_reg(CFG_SEND_PERIOD, periods[phase]);
            send_word(word_of(FUNC_POWER, 8'($urandom), 0, 0, 0, 1'b1));
            repeat (25) send_word(random_word(55, 35));
            settle();
        end
    endtask

    initial
    begin : receiver
        logic [15:0] ready_pattern;
        int          stretch;
        int          held;
        ready_pattern = 16'hFFFF;
        stretch       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                held         = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            if (stretch == 0)
            begin
                stretch = $urandom_range(16, 160);
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom) | 16'($urandom);
                    default: ready_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
                endcase
            end
            stretch--;
            out_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    always @(posedge clk)
    begin : check_bytes
        serial_out_t due;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (serial_bytes_due.size() == 0)
            begin
                $display("%0t: byte %h is_id %b last_byte %b with nothing due",
                         $time, serial_byte, is_id, last_byte);
                bad_bytes++;
            end
            else
            begin
                due = serial_bytes_due.pop_front();
                if (serial_byte !== due.data)
                begin
                    $display("%0t: serial_byte expected %h got %h",
                             $time, due.data, serial_byte);
                    bad_bytes++;
                end
                if (is_id !== due.id)
                begin
                    $display("%0t: is_id expected %b got %b", $time, due.id, is_id);
                    bad_bytes++;
                end
                if (last_byte !== due.last)
                begin
                    $display("%0t: last_byte expected %b got %b",
                             $time, due.last, last_byte);
                    bad_bytes++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : run
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_and_id();
        test_packet_layout();
        test_saturation();
        test_back_pressure();
        test_random_traffic();
        if (bad_bytes == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
